>>> src/joystick_axis_scaler_deadzone_macros.svh
// Assertion macros for the joystick axis scaler.
// Used by the top level; no other dependencies.
`ifndef JOYSTICK_AXIS_SCALER_DEADZONE_MACROS_SVH
`define JOYSTICK_AXIS_SCALER_DEADZONE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define JASD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define JASD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/jasd_pkg.sv
// Shared types and constants for the joystick axis scaler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jasd_pkg;

  // Quotient bits resolved by the divider, one per pipeline stage.
  localparam int QBITS = 7;
  // Lane depth: setup stage, divider stages, clamp stage.
  localparam int PIPE_STAGES = QBITS + 2;

  localparam logic [7:0] PCT_MAX = 8'd100;

  localparam int DIR_UP_BIT     = 0;
  localparam int DIR_DOWN_BIT   = 1;
  localparam int DIR_LEFT_BIT   = 2;
  localparam int DIR_RIGHT_BIT  = 3;
  localparam int DIR_CENTRE_BIT = 4;
  localparam int LED_BUTTON_BIT = 7;

  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_X_CENTRE  = 3'd0,
    REG_Y_CENTRE  = 3'd1,
    REG_X_LOWEST  = 3'd2,
    REG_X_HIGHEST = 3'd3,
    REG_Y_LOWEST  = 3'd4,
    REG_Y_HIGHEST = 3'd5,
    REG_DEAD_BAND = 3'd6
  } reg_idx_t;

  // Per-item flags that ride along the divider stages.
  typedef struct packed {
    logic zspan;   // span is zero
    logic pos;     // offset above centre
    logic negoff;  // offset below centre
    logic neg;     // quotient sign
  } axis_flags_t;

  typedef struct packed {
    logic signed [7:0] x_percent;
    logic signed [7:0] y_percent;
    logic [4:0]        direction_mask;
    logic              pressed;
    logic [7:0]        led_byte;
  } result_t;

endpackage

`default_nettype wire

>>> src/jasd_if.sv
// Stream interfaces for joystick samples in and scaled reports out.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface jasd_in_if #(parameter int SAMPLE_BITS = 10) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] x_sample;
  logic [SAMPLE_BITS-1:0] y_sample;
  logic                   button_pin;

  modport source(output valid, x_sample, y_sample, button_pin, input ready);
  modport sink(input valid, x_sample, y_sample, button_pin, output ready);
endinterface

interface jasd_out_if ();
  logic              valid;
  logic              ready;
  logic signed [7:0] x_percent;
  logic signed [7:0] y_percent;
  logic [4:0]        direction_mask;
  logic              pressed;
  logic [7:0]        led_byte;

  modport source(output valid, x_percent, y_percent, direction_mask, pressed, led_byte,
                 input ready);
  modport sink(input valid, x_percent, y_percent, direction_mask, pressed, led_byte,
               output ready);
endinterface

`default_nettype wire

>>> src/jasd_cfg_regs.sv
// APB-style calibration register bank.
// Depends on jasd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jasd_cfg_regs #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jasd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [SAMPLE_BITS-1:0]      x_centre_value,
  output logic [SAMPLE_BITS-1:0]      y_centre_value,
  output logic [SAMPLE_BITS-1:0]      x_lowest_value,
  output logic [SAMPLE_BITS-1:0]      x_highest_value,
  output logic [SAMPLE_BITS-1:0]      y_lowest_value,
  output logic [SAMPLE_BITS-1:0]      y_highest_value,
  output logic [SAMPLE_BITS-1:0]      dead_band
);

  logic                   wr;
  jasd_pkg::reg_idx_t     idx;
  logic [SAMPLE_BITS-1:0] wval;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = jasd_pkg::reg_idx_t'(paddr[jasd_pkg::ADDR_W-1:2]);
  assign wval   = pwdata[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      x_centre_value  <= SAMPLE_BITS'(512);
      y_centre_value  <= SAMPLE_BITS'(512);
      x_lowest_value  <= '0;
      x_highest_value <= SAMPLE_BITS'(1023);
      y_lowest_value  <= '0;
      y_highest_value <= SAMPLE_BITS'(1023);
      dead_band       <= SAMPLE_BITS'(50);
    end else if (wr) begin
      case (idx)
        jasd_pkg::REG_X_CENTRE:  x_centre_value  <= wval;
        jasd_pkg::REG_Y_CENTRE:  y_centre_value  <= wval;
        jasd_pkg::REG_X_LOWEST:  x_lowest_value  <= wval;
        jasd_pkg::REG_X_HIGHEST: x_highest_value <= wval;
        jasd_pkg::REG_Y_LOWEST:  y_lowest_value  <= wval;
        jasd_pkg::REG_Y_HIGHEST: y_highest_value <= wval;
        jasd_pkg::REG_DEAD_BAND: dead_band       <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      jasd_pkg::REG_X_CENTRE:  prdata = 32'(x_centre_value);
      jasd_pkg::REG_Y_CENTRE:  prdata = 32'(y_centre_value);
      jasd_pkg::REG_X_LOWEST:  prdata = 32'(x_lowest_value);
      jasd_pkg::REG_X_HIGHEST: prdata = 32'(x_highest_value);
      jasd_pkg::REG_Y_LOWEST:  prdata = 32'(y_lowest_value);
      jasd_pkg::REG_Y_HIGHEST: prdata = 32'(y_highest_value);
      jasd_pkg::REG_DEAD_BAND: prdata = 32'(dead_band);
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> src/jasd_axis_lane.sv
// One axis lane: centre offset, span select, pipelined restoring divide, clamp.
// Depends on jasd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jasd_axis_lane #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                             clk,
  input  logic [jasd_pkg::PIPE_STAGES-1:0] en,
  input  logic [SAMPLE_BITS-1:0]           sample,
  input  logic [SAMPLE_BITS-1:0]           centre,
  input  logic [SAMPLE_BITS-1:0]           lowest,
  input  logic [SAMPLE_BITS-1:0]           highest,
  output logic signed [7:0]                percent
);

  localparam int N    = SAMPLE_BITS;
  localparam int QB   = jasd_pkg::QBITS;
  localparam int NUMW = N + QB;

  // Stage storage, one entry per divider stage plus the setup stage.
  logic [NUMW-1:0]       rem   [QB+1];
  logic [N-1:0]          den   [QB+1];
  logic [QB-1:0]         quo   [QB+1];
  logic                  sat   [QB+1];
  jasd_pkg::axis_flags_t flags [QB+1];

  // Setup: signed offset and span, magnitudes, scaled numerator.
  logic signed [N:0]     off;
  logic signed [N:0]     span;
  logic [N-1:0]          off_mag;
  logic [N-1:0]          span_mag;
  logic [NUMW-1:0]       num0;
  jasd_pkg::axis_flags_t flags0;

  always_comb begin
    off  = $signed({1'b0, sample}) - $signed({1'b0, centre});
    span = (off > 0) ? ($signed({1'b0, highest}) - $signed({1'b0, centre}))
                     : ($signed({1'b0, centre}) - $signed({1'b0, lowest}));
    off_mag  = off[N]  ? N'(-off)  : N'(off);
    span_mag = span[N] ? N'(-span) : N'(span);
    num0     = NUMW'(off_mag) * NUMW'(jasd_pkg::PCT_MAX);
    flags0.zspan  = (span == '0);
    flags0.pos    = (off > 0);
    flags0.negoff = off[N];
    flags0.neg    = off[N] ^ span[N];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0]   <= num0;
      den[0]   <= span_mag;
      quo[0]   <= '0;
      sat[0]   <= 1'b0;
      flags[0] <= flags0;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 1; k <= QB; k++) begin : g_div
    localparam int B = QB - k;
    logic [NUMW-1:0] shifted;
    logic            ge;
    logic [QB-1:0]   quo_next;
    logic            sat_next;

    always_comb begin
      shifted  = NUMW'(den[k-1]) << B;
      ge       = (rem[k-1] >= shifted);
      quo_next = quo[k-1];
      quo_next[B] = ge;
    end

    if (k == 1) begin : g_sat
      // Quotient of 128 or more clamps regardless of the low bits.
      assign sat_next = (rem[k-1] >= (NUMW'(den[k-1]) << QB));
    end else begin : g_hold
      assign sat_next = sat[k-1];
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem[k]   <= ge ? (rem[k-1] - shifted) : rem[k-1];
        den[k]   <= den[k-1];
        quo[k]   <= quo_next;
        sat[k]   <= sat_next;
        flags[k] <= flags[k-1];
      end
    end
  end

  // Clamp and sign.
  logic [7:0]        mag;
  logic signed [7:0] percent_next;

  always_comb begin
    mag = (sat[QB] || (8'(quo[QB]) > jasd_pkg::PCT_MAX)) ? jasd_pkg::PCT_MAX : 8'(quo[QB]);
    if (flags[QB].zspan) begin
      if (flags[QB].pos) begin
        percent_next = jasd_pkg::PCT_MAX;
      end else if (flags[QB].negoff) begin
        percent_next = -jasd_pkg::PCT_MAX;
      end else begin
        percent_next = '0;
      end
    end else begin
      percent_next = flags[QB].neg ? -mag : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (en[QB+1]) begin
      percent <= percent_next;
    end
  end

endmodule

`default_nettype wire

>>> src/jasd_merge.sv
// Merge stage: deadzone direction mask, LED byte, result register.
// Depends on jasd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jasd_merge #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [7:0]      x_percent,
  input  logic signed [7:0]      y_percent,
  input  logic                   pressed,
  input  logic [SAMPLE_BITS-1:0] dead_band,
  output jasd_pkg::result_t      res
);

  localparam int W = SAMPLE_BITS + 2;

  logic signed [W-1:0] xw;
  logic signed [W-1:0] yw;
  logic signed [W-1:0] ax;
  logic signed [W-1:0] ay;
  logic signed [W-1:0] dz;
  logic [4:0]          dir;
  logic [7:0]          led;

  always_comb begin
    xw  = W'(x_percent);
    yw  = W'(y_percent);
    dz  = $signed({2'b00, dead_band});
    ax  = xw[W-1] ? -xw : xw;
    ay  = yw[W-1] ? -yw : yw;
    dir = '0;
    if ((ax > dz) || (ay > dz)) begin
      dir[jasd_pkg::DIR_UP_BIT]    = (yw > dz);
      dir[jasd_pkg::DIR_DOWN_BIT]  = (yw < -dz);
      dir[jasd_pkg::DIR_RIGHT_BIT] = (xw > dz);
      dir[jasd_pkg::DIR_LEFT_BIT]  = (xw < -dz);
    end else begin
      dir[jasd_pkg::DIR_CENTRE_BIT] = 1'b1;
    end
    led = 8'(dir);
    led[jasd_pkg::LED_BUTTON_BIT] = pressed;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.x_percent      <= x_percent;
      res.y_percent      <= y_percent;
      res.direction_mask <= dir;
      res.pressed        <= pressed;
      res.led_byte       <= led;
    end
  end

endmodule

`default_nettype wire

>>> src/joystick_axis_scaler_deadzone.sv
// Top level of the joystick axis scaler with deadzone.
// Depends on jasd_pkg, jasd_if, jasd_cfg_regs, jasd_axis_lane, jasd_merge and the macros header.
//
//   port     role         handshake          payload
//   stick    sample in    valid / ready      x_sample, y_sample, button_pin
//   report   result out   valid / ready      x_percent, y_percent, direction_mask,
//                                             pressed, led_byte
//   apb      calibration  psel/penable/wr    7 registers at 4*i, pready tied high
//
// Throughput is one sample pair per cycle while the report side is ready. Each
// axis lane has a setup register (loaded at the transfer edge), seven divider
// stages (one quotient bit per stage) and a clamp register, and the merge
// register follows: ten registers in all.
// Reset (synchronous, active high) empties the pipeline and loads the calibration
// defaults. Every stage holds when its successor is full and held, so a stalled
// result fills the pipeline from the output end while bubbles still collapse.
`timescale 1ns / 1ps
`default_nettype none

`include "joystick_axis_scaler_deadzone_macros.svh"

module joystick_axis_scaler_deadzone #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  jasd_in_if.sink                     stick,
  jasd_out_if.source                  report,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jasd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int PIPE = jasd_pkg::PIPE_STAGES;

  logic [SAMPLE_BITS-1:0] x_centre_value;
  logic [SAMPLE_BITS-1:0] y_centre_value;
  logic [SAMPLE_BITS-1:0] x_lowest_value;
  logic [SAMPLE_BITS-1:0] x_highest_value;
  logic [SAMPLE_BITS-1:0] y_lowest_value;
  logic [SAMPLE_BITS-1:0] y_highest_value;
  logic [SAMPLE_BITS-1:0] dead_band;

  // Calibration registers.
  jasd_cfg_regs #(.SAMPLE_BITS(SAMPLE_BITS)) u_cfg (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .x_centre_value  (x_centre_value),
    .y_centre_value  (y_centre_value),
    .x_lowest_value  (x_lowest_value),
    .x_highest_value (x_highest_value),
    .y_lowest_value  (y_lowest_value),
    .y_highest_value (y_highest_value),
    .dead_band       (dead_band)
  );

  // Stage occupancy: stages 0..PIPE-1 are the lanes, stage PIPE is the result register.
  logic [PIPE:0] vld;
  logic [PIPE:0] adv;

  // A stage may load when it is empty or its contents move on this cycle.
  always_comb begin
    adv[PIPE] = !vld[PIPE] || report.ready;
    for (int i = PIPE - 1; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= stick.valid;
      end
      for (int i = 1; i <= PIPE; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign stick.ready  = adv[0];
  assign report.valid = vld[PIPE];

  // Carry the button flag alongside the lanes.
  logic press_pipe [PIPE];

  for (genvar s = 0; s < PIPE; s++) begin : g_press
    always_ff @(posedge clk) begin
      if (adv[s]) begin
        press_pipe[s] <= (s == 0) ? !stick.button_pin : press_pipe[(s == 0) ? 0 : s - 1];
      end
    end
  end

  logic signed [7:0] x_pct;
  logic signed [7:0] y_pct;

  // X and Y lanes run side by side on the same stage enables.
  jasd_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
    .clk     (clk),
    .en      (adv[PIPE-1:0]),
    .sample  (stick.x_sample),
    .centre  (x_centre_value),
    .lowest  (x_lowest_value),
    .highest (x_highest_value),
    .percent (x_pct)
  );

  jasd_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
    .clk     (clk),
    .en      (adv[PIPE-1:0]),
    .sample  (stick.y_sample),
    .centre  (y_centre_value),
    .lowest  (y_lowest_value),
    .highest (y_highest_value),
    .percent (y_pct)
  );

  jasd_pkg::result_t res;

  // Combine both axes into the direction mask and LED byte; hold the result here.
  jasd_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
    .clk       (clk),
    .en        (adv[PIPE]),
    .x_percent (x_pct),
    .y_percent (y_pct),
    .pressed   (press_pipe[PIPE-1]),
    .dead_band (dead_band),
    .res       (res)
  );

  assign report.x_percent      = res.x_percent;
  assign report.y_percent      = res.y_percent;
  assign report.direction_mask = res.direction_mask;
  assign report.pressed        = res.pressed;
  assign report.led_byte       = res.led_byte;

  // Checks.
  logic pct_ok;
  logic led_ok;

  assign pct_ok = (report.x_percent <= 8'sd100) && (report.x_percent >= -8'sd100) &&
                  (report.y_percent <= 8'sd100) && (report.y_percent >= -8'sd100);
  assign led_ok = (report.led_byte[4:0] == report.direction_mask) &&
                  (report.led_byte[7] == report.pressed) && (report.led_byte[6:5] == 2'd0);

  `JASD_ASSERT_NXT(a_accept_fills, clk, rst, stick.valid && stick.ready, vld[0], "transfer in lost")
  `JASD_ASSERT_IMP(a_pct_range, clk, rst, report.valid, pct_ok, "percent outside clamp range")
  `JASD_ASSERT_IMP(a_centre_alone, clk, rst, report.valid && report.direction_mask[4], report.direction_mask[3:0] == 4'd0, "centre mixed with a direction")
  `JASD_ASSERT_IMP(a_led_match, clk, rst, report.valid, led_ok, "LED byte disagrees with mask or button")

endmodule

`default_nettype wire
